@@ sv/byte_ring_buffer_chunked_macros.svh @@
// ----------------------------------------------------------------------------
// byte_ring_buffer_chunked assertion macros
// Immediate-implication and next-cycle assertion helpers, compiled out in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_CHUNKED_MACROS_SVH
`define BYTE_RING_BUFFER_CHUNKED_MACROS_SVH

`ifndef SYNTH
`define BRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BRB_ASSERT_NOW(label, ante, cons)
`define BRB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/brb_pkg.sv @@
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants of the chunked byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int RING_BYTES_DEF = 1024;
  localparam int MAX_CHUNK      = 8;

  localparam logic [2:0] OP_ENQ   = 3'd0;
  localparam logic [2:0] OP_DEQ   = 3'd1;
  localparam logic [2:0] OP_PEEK  = 3'd2;
  localparam logic [2:0] OP_RESET = 3'd3;
  localparam logic [2:0] OP_WSPAN = 3'd4;
  localparam logic [2:0] OP_RSPAN = 3'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  length;
    logic [63:0] in_bytes;
  } brb_in_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] out_bytes;
    logic [9:0]  first_span;
    logic [9:0]  second_span;
  } brb_out_t;

  typedef struct packed {
    logic idle;
    logic done;
  } brb_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DONE
  } brb_state_t;

endpackage

@@ sv/brb_ram.sv @@
// ----------------------------------------------------------------------------
// brb_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/brb_engine.sv @@
// ----------------------------------------------------------------------------
// brb_engine
// Ring indices, op decode and a byte-serial sequencer around the byte store.
// ----------------------------------------------------------------------------
module brb_engine #(
  parameter int RING_BYTES = brb_pkg::RING_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_go,
  input  brb_pkg::brb_in_t  req,
  input  logic              take,
  output brb_pkg::brb_stat_t stat,
  output brb_pkg::brb_out_t res
);

  localparam int IW = $clog2(RING_BYTES);
  localparam int CW = (IW + 1 > 4) ? IW + 1 : 4;
  localparam logic [IW:0]   N_W      = (IW + 1)'(RING_BYTES);
  localparam logic [IW:0]   ONE_W    = (IW + 1)'(1);
  localparam logic [IW-1:0] LAST_IDX = IW'(RING_BYTES - 1);

  brb_pkg::brb_state_t state, state_next;

  logic [IW-1:0] wr_idx, rd_idx, pos;
  logic [3:0]    cnt, len_q;
  logic [63:0]   data_q;
  logic          is_deq;
  logic          g_vld;
  logic [2:0]    g_slot;
  brb_pkg::brb_out_t res_q, res_new;

  logic          ram_we;
  logic [IW-1:0] ram_addr;
  logic [7:0]    ram_rdata;
  logic          issue;
  logic          rd_last;

  logic [IW:0]   wr_e, rd_e, used, room, first, second;
  logic [CW-1:0] len_c, used_c, room_c;
  logic          full, empty, len_ok, enq_go, rd_go;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  brb_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (data_q[7:0]),
    .rdata (ram_rdata)
  );

  // Fill level, free space and op decode from the current indices.
  always_comb begin
    wr_e   = {1'b0, wr_idx};
    rd_e   = {1'b0, rd_idx};
    used   = (wr_idx >= rd_idx) ? wr_e - rd_e : wr_e + N_W - rd_e;
    room   = N_W - ONE_W - used;
    full   = (used == N_W - ONE_W);
    empty  = (used == '0);
    len_c  = CW'(req.length);
    used_c = CW'(used);
    room_c = CW'(room);
    len_ok = (req.length <= 4'(brb_pkg::MAX_CHUNK));
    enq_go = (req.op == brb_pkg::OP_ENQ) && !full && len_ok && (len_c <= room_c);
    rd_go  = ((req.op == brb_pkg::OP_DEQ) || (req.op == brb_pkg::OP_PEEK)) &&
             !empty && len_ok && (len_c <= used_c);

    first  = '0;
    second = '0;
    if (req.op == brb_pkg::OP_WSPAN && !full) begin
      if (wr_idx < rd_idx) begin
        first = rd_e - ONE_W - wr_e;
      end else if (rd_idx == '0) begin
        first = N_W - wr_e - ONE_W;
      end else begin
        first  = N_W - wr_e;
        second = rd_e - ONE_W;
      end
    end else if (req.op == brb_pkg::OP_RSPAN) begin
      if (rd_idx < wr_idx) begin
        first = wr_e - rd_e;
      end else if (wr_idx < rd_idx) begin
        first  = N_W - rd_e;
        second = wr_e;
      end
    end

    res_new             = '0;
    res_new.first_span  = 10'(first);
    res_new.second_span = 10'(second);
    case (req.op)
      brb_pkg::OP_ENQ:   res_new.ok = enq_go;
      brb_pkg::OP_DEQ:   res_new.ok = rd_go;
      brb_pkg::OP_PEEK:  res_new.ok = rd_go;
      brb_pkg::OP_RESET: res_new.ok = 1'b1;
      brb_pkg::OP_WSPAN: res_new.ok = (room != '0);
      brb_pkg::OP_RSPAN: res_new.ok = (used != '0);
      default:           res_new.ok = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      brb_pkg::ST_IDLE: begin
        if (req_go) begin
          if (enq_go && req.length != 4'd0) begin
            state_next = brb_pkg::ST_WRITE;
          end else if (rd_go && req.length != 4'd0) begin
            state_next = brb_pkg::ST_READ;
          end else begin
            state_next = brb_pkg::ST_DONE;
          end
        end
      end
      brb_pkg::ST_WRITE: begin
        if (cnt + 4'd1 == len_q) begin
          state_next = brb_pkg::ST_DONE;
        end
      end
      brb_pkg::ST_READ: begin
        if (rd_last) begin
          state_next = brb_pkg::ST_DONE;
        end
      end
      brb_pkg::ST_DONE: begin
        if (take) begin
          state_next = brb_pkg::ST_IDLE;
        end
      end
      default: state_next = brb_pkg::ST_IDLE;
    endcase
  end

  // Store port and status.
  always_comb begin
    ram_we    = (state == brb_pkg::ST_WRITE);
    ram_addr  = (state == brb_pkg::ST_WRITE) ? wr_idx : pos;
    issue     = (state == brb_pkg::ST_READ) && (cnt != len_q);
    rd_last   = (state == brb_pkg::ST_READ) && (cnt == len_q) && g_vld;
    stat.idle = (state == brb_pkg::ST_IDLE);
    stat.done = (state == brb_pkg::ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= brb_pkg::ST_IDLE;
      wr_idx <= '0;
      rd_idx <= '0;
      g_vld  <= 1'b0;
    end else begin
      state <= state_next;
      g_vld <= issue;
      if (stat.idle && req_go) begin
        if (req.op == brb_pkg::OP_RESET) begin
          wr_idx <= '0;
          rd_idx <= '0;
        end
      end
      if (ram_we) begin
        wr_idx <= idx_inc(wr_idx);
      end
      // Commit the read index only once the whole chunk is gathered.
      if (rd_last && is_deq) begin
        rd_idx <= pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    g_slot <= cnt[2:0];
    if (stat.idle && req_go) begin
      res_q  <= res_new;
      cnt    <= 4'd0;
      len_q  <= req.length;
      data_q <= req.in_bytes;
      is_deq <= (req.op == brb_pkg::OP_DEQ);
      pos    <= rd_idx;
    end
    if (ram_we) begin
      data_q <= data_q >> 8;
      cnt    <= cnt + 4'd1;
    end
    if (issue) begin
      pos <= idx_inc(pos);
      cnt <= cnt + 4'd1;
    end
    if (g_vld) begin
      res_q.out_bytes[{g_slot, 3'b000} +: 8] <= ram_rdata;
    end
  end

  assign res = res_q;

endmodule

@@ sv/byte_ring_buffer_chunked.sv @@
// ----------------------------------------------------------------------------
// byte_ring_buffer_chunked
// Circular byte FIFO with chunked enqueue, dequeue, peek and span queries.
// ----------------------------------------------------------------------------
// Requests arrive on req (op, length, in_bytes) under req_valid/req_stall;
// one response per request leaves on rsp under rsp_valid/rsp_stall.
// The buffer keeps one slot free, so it holds at most RING_BYTES-1 bytes.
// Bytes move one per cycle through a single-port byte store; dequeue and peek
// gather their bytes from its registered read data. Reset, span queries,
// refused and zero-length ops move no bytes and go straight to the result.
// One request is in work at a time; the next one is accepted as soon as the
// previous result sits in the output register, even while that is stalled.
// A stalled response holds rsp steady; a finished result waits inside the
// engine until the output register frees up.
// Reset (rst, synchronous) clears both indices and empties the pipeline; the
// byte store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "byte_ring_buffer_chunked_macros.svh"

module byte_ring_buffer_chunked #(
  parameter int RING_BYTES = brb_pkg::RING_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  brb_pkg::brb_in_t  req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output brb_pkg::brb_out_t rsp
);

  brb_pkg::brb_stat_t stat;
  brb_pkg::brb_out_t  res;
  logic               req_go;
  logic               take;

  assign req_stall = !stat.idle;
  assign req_go    = req_valid && !req_stall;
  assign take      = !rsp_valid || !rsp_stall;

  brb_engine #(.RING_BYTES(RING_BYTES)) u_engine (
    .clk    (clk),
    .rst    (rst),
    .req_go (req_go),
    .req    (req),
    .take   (take),
    .stat   (stat),
    .res    (res)
  );

  // Output register: load a finished item, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (stat.done && take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && take) begin
      rsp <= res;
    end
  end

  `BRB_ASSERT_NEXT(a_busy_after_accept, req_go, req_stall)
  `BRB_ASSERT_NEXT(a_result_held, stat.done && !take, stat.done)
  `BRB_ASSERT_NOW(a_refused_no_data, rsp_valid && !rsp.ok, rsp.out_bytes == 64'd0)

endmodule

@@ tb/byte_ring_buffer_chunked_checker.sv @@
// ----------------------------------------------------------------------------
// byte_ring_buffer_chunked_checker
// Watches both channels of the ring buffer and keeps its own copy of the
// byte store and indices. Predicts the response to every accepted request
// and compares each accepted response, field by field, with the oldest
// prediction.
// ----------------------------------------------------------------------------
module byte_ring_buffer_chunked_checker
  import brb_pkg::*;
#(
  parameter int RING_BYTES = brb_pkg::RING_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_stall,
  input  brb_in_t  req,
  input  logic     rsp_valid,
  input  logic     rsp_stall,
  input  brb_out_t rsp,
  output int       mismatches,
  output int       awaited
);

  logic [7:0] ring_mem [RING_BYTES];
  int         wr_ptr = 0;
  int         rd_ptr = 0;
  brb_out_t   due_rsp_q [$];
  int         fail_tally = 0;
  int         due_count = 0;

  assign mismatches = fail_tally;
  assign awaited    = due_count;

  task automatic apply_ring_op(input brb_in_t it, output brb_out_t res);
    int used;
    int room;
    int first;
    int second;
    int i;
    res    = '0;
    first  = 0;
    second = 0;
    used   = (wr_ptr + RING_BYTES - rd_ptr) % RING_BYTES;
    room   = RING_BYTES - 1 - used;
    case (it.op)
      OP_ENQ: begin
        if (used != RING_BYTES - 1 && it.length <= MAX_CHUNK && it.length <= room) begin
          for (i = 0; i < it.length; i++) begin
            ring_mem[wr_ptr] = it.in_bytes[8*i +: 8];
            wr_ptr = (wr_ptr + 1) % RING_BYTES;
          end
          res.ok = 1'b1;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (used != 0 && it.length <= MAX_CHUNK && it.length <= used) begin
          for (i = 0; i < it.length; i++)
            res.out_bytes[8*i +: 8] = ring_mem[(rd_ptr + i) % RING_BYTES];
          if (it.op == OP_DEQ)
            rd_ptr = (rd_ptr + it.length) % RING_BYTES;
          res.ok = 1'b1;
        end
      end
      OP_RESET: begin
        wr_ptr = 0;
        rd_ptr = 0;
        res.ok = 1'b1;
      end
      OP_WSPAN: begin
        // one slot always stays free, so the span stops one short of rd_ptr
        if (used != RING_BYTES - 1) begin
          if (wr_ptr < rd_ptr) begin
            first = rd_ptr - 1 - wr_ptr;
          end else if (rd_ptr == 0) begin
            first = RING_BYTES - wr_ptr - 1;
          end else begin
            first  = RING_BYTES - wr_ptr;
            second = rd_ptr - 1;
          end
        end
        res.ok = (first + second) != 0;
      end
      OP_RSPAN: begin
        if (rd_ptr < wr_ptr) begin
          first = wr_ptr - rd_ptr;
        end else if (wr_ptr < rd_ptr) begin
          first  = RING_BYTES - rd_ptr;
          second = wr_ptr;
        end
        res.ok = (first + second) != 0;
      end
      default: res = '0;
    endcase
    res.first_span  = first[9:0];
    res.second_span = second[9:0];
  endtask

  task automatic report_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      fail_tally++;
    end
  endtask

  // Sample mid-cycle: inputs and outputs are settled until the next rising edge.
  always @(negedge clk) begin
    brb_out_t want;
    if (rst) begin
      wr_ptr = 0;
      rd_ptr = 0;
      due_rsp_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp_q.size() == 0) begin
          $display("%0t: unexpected response: expected none, actual %h", $time, rsp);
          fail_tally++;
        end else begin
          want = due_rsp_q.pop_front();
          report_field("ok", 64'(want.ok), 64'(rsp.ok));
          report_field("out_bytes", want.out_bytes, rsp.out_bytes);
          report_field("first_span", 64'(want.first_span), 64'(rsp.first_span));
          report_field("second_span", 64'(want.second_span), 64'(rsp.second_span));
        end
      end
      if (req_valid && !req_stall) begin
        apply_ring_op(req, want);
        due_rsp_q.push_back(want);
      end
    end
    due_count = due_rsp_q.size();
  end

endmodule

@@ tb/byte_ring_buffer_chunked_tb.sv @@
// ----------------------------------------------------------------------------
// byte_ring_buffer_chunked_tb
// Drives the ring buffer with a short directed run over every op and corner,
// then with phases that fill, stir and drain the buffer so it reaches full,
// empty and wraps around. Both sides idle in random bursts; the checker
// beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module byte_ring_buffer_chunked_tb;
  import brb_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 24;
  localparam int CALM_FROM      = 700;

  typedef enum int {FILL_PHASE, MIXED_PHASE, DRAIN_PHASE} phase_e;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  brb_in_t  req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  brb_out_t rsp;

  logic     calm = 1'b0;
  logic     idle_on = 1'b1;
  int       mismatches;
  int       awaited;
  int       quiet_cycles = 0;

  phase_e   plan_phase [5] = '{FILL_PHASE, MIXED_PHASE, DRAIN_PHASE, FILL_PHASE, MIXED_PHASE};
  int       plan_items [5] = '{260, 100, 200, 140, 100};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  byte_ring_buffer_chunked dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  byte_ring_buffer_chunked_checker ring_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  function automatic brb_in_t mk_item(input logic [2:0] op, input logic [3:0] len,
                                      input logic [63:0] bytes_in);
    brb_in_t it;
    it.op       = op;
    it.length   = len;
    it.in_bytes = bytes_in;
    return it;
  endfunction

  function automatic brb_in_t make_item(input phase_e phase);
    brb_in_t it;
    int pick;
    int lsel;
    pick        = $urandom_range(0, 99);
    lsel        = $urandom_range(0, 99);
    it.in_bytes = {$urandom, $urandom};
    // favor full chunks so fill and drain phases actually reach the ends
    if (lsel < 55)
      it.length = 4'd8;
    else if (lsel < 92)
      it.length = 4'($urandom_range(0, 7));
    else
      it.length = 4'($urandom_range(9, 15));
    case (phase)
      FILL_PHASE:
        it.op = pick < 85 ? OP_ENQ : pick < 92 ? OP_DEQ : pick < 95 ? OP_PEEK :
                pick < 97 ? OP_WSPAN : OP_RSPAN;
      DRAIN_PHASE:
        it.op = pick < 80 ? OP_DEQ : pick < 88 ? OP_PEEK : pick < 93 ? OP_ENQ :
                pick < 96 ? OP_WSPAN : OP_RSPAN;
      default:
        it.op = pick < 35 ? OP_ENQ : pick < 65 ? OP_DEQ : pick < 77 ? OP_PEEK :
                pick < 85 ? OP_WSPAN : pick < 93 ? OP_RSPAN : pick < 95 ? OP_RESET :
                3'($urandom_range(6, 7));
    endcase
    return it;
  endfunction

  task automatic send_item(input brb_in_t it);
    bit taken;
    if (!calm && idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !req_stall;
      @(posedge clk);
    end
  endtask

  // Hold the response channel off in random bursts.
  always begin
    @(posedge clk);
    if (!rst && !calm && idle_on && $urandom_range(0, 5) == 0) begin
      rsp_stall <= 1'b1;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    rsp_stall <= 1'b0;
  end

  always @(negedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** byte_ring_buffer_chunked: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int seg;
    int k;
    sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty buffer refusals and spans
    send_item(mk_item(OP_DEQ, 4'd0, 64'd0));
    send_item(mk_item(OP_PEEK, 4'd0, 64'd0));
    send_item(mk_item(OP_RSPAN, 4'd0, 64'd0));
    send_item(mk_item(OP_WSPAN, 4'd0, 64'd0));
    send_item(mk_item(OP_ENQ, 4'd0, '1));
    send_item(mk_item(OP_ENQ, 4'd8, '1));
    // oversize chunks
    send_item(mk_item(OP_ENQ, 4'd9, 64'h0123_4567_89ab_cdef));
    send_item(mk_item(OP_ENQ, 4'd15, '1));
    send_item(mk_item(OP_PEEK, 4'd8, 64'd0));
    send_item(mk_item(OP_PEEK, 4'd9, 64'd0));
    send_item(mk_item(OP_DEQ, 4'd3, 64'd0));
    // short data
    send_item(mk_item(OP_DEQ, 4'd8, 64'd0));
    send_item(mk_item(OP_RSPAN, 4'd0, 64'd0));
    send_item(mk_item(OP_WSPAN, 4'd0, 64'd0));
    send_item(mk_item(OP_DEQ, 4'd5, 64'd0));
    send_item(mk_item(OP_PEEK, 4'd1, 64'd0));
    send_item(mk_item(OP_ENQ, 4'd8, 64'd0));
    send_item(mk_item(OP_ENQ, 4'd1, 64'hffff_ffff_ffff_ffa5));
    // unknown ops
    send_item(mk_item(3'd6, 4'd15, '1));
    send_item(mk_item(3'd7, 4'd15, '1));
    send_item(mk_item(OP_RESET, 4'd15, '1));
    send_item(mk_item(OP_RSPAN, 4'd0, 64'd0));
    send_item(mk_item(OP_ENQ, 4'd8, {$urandom, $urandom}));
    send_item(mk_item(OP_DEQ, 4'd0, 64'd0));
    send_item(mk_item(OP_WSPAN, 4'd0, 64'd0));

    for (seg = 0; seg < 5; seg++) begin
      idle_on <= ($urandom_range(0, 3) != 0);
      for (k = 0; k < plan_items[seg]; k++) begin
        if (sent >= CALM_FROM)
          calm <= 1'b1;
        send_item(make_item(plan_phase[seg]));
        sent++;
      end
    end
    req_valid <= 1'b0;

    while (awaited != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited == 0)
      $display("** byte_ring_buffer_chunked: PASSED **");
    else
      $display("** byte_ring_buffer_chunked: FAILED **");
    $finish;
  end

endmodule
